@@ src/rcbs_pkg.sv @@
// Shared types, field widths and score helper for the root candidate selector.
package rcbs_pkg;

	localparam int unsigned PREF_W  = 8;
	localparam int unsigned STRAT_W = 8;
	localparam int unsigned SIG_W   = 8;
	localparam int unsigned ID_W    = 64;
	localparam int unsigned SCORE_W = 10;
	localparam int unsigned IDX_W   = 8;
	localparam int unsigned IN_DATA_W  = PREF_W + STRAT_W + 2 * SIG_W + ID_W;
	localparam int unsigned OUT_USER_W = 2;

	// bit positions in the result tuser
	localparam int unsigned USER_FOUND = 0;
	localparam int unsigned USER_OVER  = 1;

	typedef logic signed [SCORE_W-1:0] score_t;

	typedef struct packed {
		logic [ID_W-1:0]    eui_id;
		logic signed [SIG_W-1:0] snr_avg;
		logic signed [SIG_W-1:0] rssi_avg;
		logic [STRAT_W-1:0] strat_level;
		logic [PREF_W-1:0]  dodag_pref;
	} cand_t;

	// score = 2*rssi + snr, always fits in ten signed bits
	function automatic score_t calc_score(logic signed [SIG_W-1:0] rssi,
			logic signed [SIG_W-1:0] snr);
		score_t r2;
		score_t s1;
		r2 = {rssi[SIG_W-1], rssi, 1'b0};
		s1 = {{(SCORE_W-SIG_W){snr[SIG_W-1]}}, snr};
		return r2 + s1;
	endfunction

endpackage

@@ src/root_candidate_best_select.sv @@
// Top level: streaming lexicographic best-candidate selector over a run of root candidates.
// The single stage's held-best compare sets a rate of one candidate per cycle,
// unless a last item stalls. The result register is loaded as a run's last item moves on.
// A last item stalls in the input register only while the result register is still full.
// Reset (arst_n low) empties both registers and clears the held best, count and overflow.
module root_candidate_best_select #(
	parameter int unsigned MAX_CANDIDATES = 256
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// dodag_pref[7:0], strat_level[15:8], rssi_avg[23:16], snr_avg[31:24], eui_id[95:32]
	input  logic [rcbs_pkg::IN_DATA_W-1:0] s_axis_tdata,
	// sig_ok
	input  logic s_axis_tuser,
	input  logic s_axis_tlast,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// best_idx[7:0]
	output logic [rcbs_pkg::IDX_W-1:0] m_axis_tdata,
	// found[0], overflow[1]
	output logic [rcbs_pkg::OUT_USER_W-1:0] m_axis_tuser
);

	localparam int unsigned POS_W = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
	localparam int unsigned CNT_W = $clog2(MAX_CANDIDATES + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_CANDIDATES);

	// input register
	logic           valid_s1;
	rcbs_pkg::cand_t cand_s1;
	logic           sig_s1;
	logic           last_s1;

	// held best and run state
	logic                       have_q;
	logic [rcbs_pkg::PREF_W-1:0]  pref_q;
	logic [rcbs_pkg::STRAT_W-1:0] strat_q;
	rcbs_pkg::score_t           score_q;
	logic [rcbs_pkg::ID_W-1:0]    id_q;
	logic [POS_W-1:0]           pos_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       over_q;

	// result register
	logic                             out_valid_q;
	logic [rcbs_pkg::IDX_W-1:0]       out_idx_q;
	logic [rcbs_pkg::OUT_USER_W-1:0]  out_user_q;

	logic             out_free;
	logic             go_s1;
	logic             in_xfer;
	rcbs_pkg::score_t score_c;
	logic             selectable;
	logic             beats;
	logic             take;
	logic             have_n;
	logic [POS_W-1:0] pos_n;
	logic             over_n;
	logic [POS_W+rcbs_pkg::IDX_W-1:0] pos_ext;

	assign out_free      = !out_valid_q || m_axis_tready;
	assign go_s1         = valid_s1 && (!last_s1 || out_free);
	assign s_axis_tready = !valid_s1 || go_s1;
	assign in_xfer       = s_axis_tvalid && s_axis_tready;

	assign score_c    = rcbs_pkg::calc_score(cand_s1.rssi_avg, cand_s1.snr_avg);
	assign selectable = cnt_q < CNT_MAX;

	always_comb begin
		priority if (cand_s1.dodag_pref != pref_q) begin
			beats = cand_s1.dodag_pref > pref_q;
		end else if (cand_s1.strat_level != strat_q) begin
			beats = cand_s1.strat_level < strat_q;
		end else if (score_c != score_q) begin
			beats = score_c > score_q;
		end else begin
			beats = cand_s1.eui_id < id_q;
		end
	end

	assign take    = selectable && sig_s1 && (!have_q || beats);
	assign have_n  = have_q || take;
	assign pos_n   = take ? cnt_q[POS_W-1:0] : pos_q;
	assign over_n  = over_q || !selectable;
	assign pos_ext = {{rcbs_pkg::IDX_W{1'b0}}, pos_n};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cand_s1 <= rcbs_pkg::cand_t'(s_axis_tdata);
			sig_s1  <= s_axis_tuser;
			last_s1 <= s_axis_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q  <= 1'b0;
			pref_q  <= '0;
			strat_q <= '0;
			score_q <= '0;
			id_q    <= '0;
			pos_q   <= '0;
			cnt_q   <= '0;
			over_q  <= 1'b0;
		end else if (go_s1) begin
			if (last_s1) begin
				// clear for the next run
				have_q  <= 1'b0;
				pref_q  <= '0;
				strat_q <= '0;
				score_q <= '0;
				id_q    <= '0;
				pos_q   <= '0;
				cnt_q   <= '0;
				over_q  <= 1'b0;
			end else begin
				have_q <= have_n;
				pos_q  <= pos_n;
				over_q <= over_n;
				if (selectable) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
				if (take) begin
					pref_q  <= cand_s1.dodag_pref;
					strat_q <= cand_s1.strat_level;
					score_q <= score_c;
					id_q    <= cand_s1.eui_id;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && last_s1) begin
			out_idx_q                       <= have_n ? pos_ext[rcbs_pkg::IDX_W-1:0] : '0;
			out_user_q[rcbs_pkg::USER_FOUND] <= have_n;
			out_user_q[rcbs_pkg::USER_OVER]  <= over_n;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_idx_q;
	assign m_axis_tuser  = out_user_q;

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		go_s1 && last_s1 |=> cnt_q == '0 && !have_q && !over_q)
		else $error("run state not cleared after last item");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_MAX)
		else $error("position counter past capacity");

	a_over_saturated: assert property (@(posedge clk) disable iff (!arst_n)
		over_q |-> cnt_q == CNT_MAX)
		else $error("overflow set before counter saturated");

	a_not_found_idx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_user_q[rcbs_pkg::USER_FOUND] |-> out_idx_q == '0)
		else $error("nonzero index without a found candidate");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_axis_tready)
		else $error("input stalled with empty input register");

endmodule

@@ bench/best_select_check.sv @@
// Checker for the root candidate selector: predicts each run's winner and compares results.
module best_select_check #(
	parameter int unsigned MAX_CANDIDATES = 256
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	input  logic s_axis_tready,
	// dodag_pref[7:0], strat_level[15:8], rssi_avg[23:16], snr_avg[31:24], eui_id[95:32]
	input  logic [rcbs_pkg::IN_DATA_W-1:0] s_axis_tdata,
	// sig_ok
	input  logic s_axis_tuser,
	input  logic s_axis_tlast,
	input  logic m_axis_tvalid,
	input  logic m_axis_tready,
	// best_idx[7:0]
	input  logic [rcbs_pkg::IDX_W-1:0] m_axis_tdata,
	// found[0], overflow[1]
	input  logic [rcbs_pkg::OUT_USER_W-1:0] m_axis_tuser,
	output int   fail_count,
	output int   winners_owed
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic                       found;
		logic [rcbs_pkg::IDX_W-1:0] idx;
		logic                       over;
	} verdict_t;

	// leading candidate of the current run
	logic                         lead_valid;
	logic [rcbs_pkg::PREF_W-1:0]  lead_pref;
	logic [rcbs_pkg::STRAT_W-1:0] lead_strat;
	rcbs_pkg::score_t             lead_score;
	logic [rcbs_pkg::ID_W-1:0]    lead_id;
	logic [rcbs_pkg::IDX_W-1:0]   lead_pos;
	int unsigned                  run_pos;
	logic                         run_spill;

	verdict_t winners_q[$];
	int       fails = 0;

	function automatic void clear_run();
		lead_valid = 1'b0;
		lead_pref  = '0;
		lead_strat = '0;
		lead_score = '0;
		lead_id    = '0;
		lead_pos   = '0;
		run_pos    = 0;
		run_spill  = 1'b0;
	endfunction

	// strict ranking: preference up, stratum down, score up, identifier down
	function automatic logic outranks(rcbs_pkg::cand_t c, rcbs_pkg::score_t sc);
		if (c.dodag_pref != lead_pref)
			return c.dodag_pref > lead_pref;
		if (c.strat_level != lead_strat)
			return c.strat_level < lead_strat;
		if (sc != lead_score)
			return sc > lead_score;
		return c.eui_id < lead_id;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rcbs_pkg::cand_t  c;
		rcbs_pkg::score_t sc;
		verdict_t         got;
		verdict_t         want;
		if (!arst_n) begin
			clear_run();
			winners_q.delete();
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.found = m_axis_tuser[rcbs_pkg::USER_FOUND];
				got.idx   = m_axis_tdata;
				got.over  = m_axis_tuser[rcbs_pkg::USER_OVER];
				if (winners_q.size() == 0) begin
					fails++;
					$error("result with no run pending: found=%0b best_idx=%0d overflow=%0b",
						got.found, got.idx, got.over);
				end else begin
					want = winners_q.pop_front();
					if (got.found !== want.found) begin
						fails++;
						$error("found mismatch: expected %0b, actual %0b", want.found, got.found);
					end
					if (got.idx !== want.idx) begin
						fails++;
						$error("best_idx mismatch: expected %0d, actual %0d", want.idx, got.idx);
					end
					if (got.over !== want.over) begin
						fails++;
						$error("overflow mismatch: expected %0b, actual %0b", want.over, got.over);
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				c  = rcbs_pkg::cand_t'(s_axis_tdata);
				sc = rcbs_pkg::score_t'(2 * int'($signed(c.rssi_avg)) +
					int'($signed(c.snr_avg)));
				if (run_pos >= MAX_CANDIDATES) begin
					// past capacity: flag only, never selectable
					run_spill = 1'b1;
				end else begin
					if (s_axis_tuser && (!lead_valid || outranks(c, sc))) begin
						lead_valid = 1'b1;
						lead_pref  = c.dodag_pref;
						lead_strat = c.strat_level;
						lead_score = sc;
						lead_id    = c.eui_id;
						lead_pos   = rcbs_pkg::IDX_W'(run_pos);
					end
					run_pos++;
				end
				if (s_axis_tlast) begin
					want.found = lead_valid;
					want.idx   = lead_valid ? lead_pos : '0;
					want.over  = run_spill;
					winners_q.push_back(want);
					clear_run();
				end
			end
		end
		fail_count   <= fails;
		winners_owed <= winners_q.size();
	end

endmodule

@@ bench/tb_top.sv @@
// Top of the selector bench: clock, reset, candidate runs, result back-pressure and verdict.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned MAX_CANDIDATES = 256;
	localparam int ITEMS_TOTAL = 1150;

	logic                            clk           = 1'b0;
	logic                            arst_n        = 1'b0;
	logic                            s_axis_tvalid = 1'b0;
	logic                            s_axis_tready;
	logic [rcbs_pkg::IN_DATA_W-1:0]  s_axis_tdata  = '0;
	logic                            s_axis_tuser  = 1'b0;
	logic                            s_axis_tlast  = 1'b0;
	logic                            m_axis_tvalid;
	logic                            m_axis_tready = 1'b0;
	logic [rcbs_pkg::IDX_W-1:0]      m_axis_tdata;
	logic [rcbs_pkg::OUT_USER_W-1:0] m_axis_tuser;

	int fails;
	int owed;
	int items_sent  = 0;
	bit send_steady = 1'b0;
	bit recv_steady = 1'b0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	root_candidate_best_select #(
		.MAX_CANDIDATES(MAX_CANDIDATES)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	best_select_check #(
		.MAX_CANDIDATES(MAX_CANDIDATES)
	) u_check (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.fail_count(fails),
		.winners_owed(owed)
	);

	// offer one candidate and hold it until the transfer
	task automatic push_cand(input rcbs_pkg::cand_t c, input logic sig, input logic last);
		int gap;
		gap = send_steady ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= c;
		s_axis_tuser  <= sig;
		s_axis_tlast  <= last;
		do @(posedge clk); while (!s_axis_tready);
		items_sent++;
	endtask

	task automatic push_fields(input logic [7:0] pref, input logic [7:0] strat,
			input logic [7:0] rssi, input logic [7:0] snr, input logic [63:0] id,
			input logic sig, input logic last);
		rcbs_pkg::cand_t c;
		c.dodag_pref  = pref;
		c.strat_level = strat;
		c.rssi_avg    = rssi;
		c.snr_avg     = snr;
		c.eui_id      = id;
		push_cand(c, sig, last);
	endtask

	function automatic rcbs_pkg::cand_t fresh_cand();
		rcbs_pkg::cand_t c;
		c.dodag_pref  = 8'($urandom);
		c.strat_level = 8'($urandom);
		c.rssi_avg    = 8'($urandom);
		c.snr_avg     = 8'($urandom);
		c.eui_id      = {$urandom, $urandom};
		return c;
	endfunction

	// close relative of the run's base, so that ties reach the later ranking keys
	function automatic rcbs_pkg::cand_t vary_cand(rcbs_pkg::cand_t base);
		rcbs_pkg::cand_t c;
		c = fresh_cand();
		if ($urandom_range(0, 3) != 0) c.dodag_pref  = base.dodag_pref;
		if ($urandom_range(0, 2) != 0) c.strat_level = base.strat_level;
		if ($urandom_range(0, 1) != 0) begin
			c.rssi_avg = base.rssi_avg;
			c.snr_avg  = base.snr_avg;
		end
		if ($urandom_range(0, 2) != 0) c.eui_id = base.eui_id;
		case ($urandom_range(0, 7))
			0: begin
				// same score from a different rssi/snr split
				c.rssi_avg = base.rssi_avg + 8'sd1;
				c.snr_avg  = base.snr_avg - 8'sd2;
			end
			1: c.dodag_pref  = $urandom_range(0, 1) ? 8'hFF : 8'h00;
			2: c.strat_level = $urandom_range(0, 1) ? 8'hFF : 8'h00;
			3: c.eui_id      = $urandom_range(0, 1) ? '1 : '0;
			4: begin
				c.rssi_avg = $urandom_range(0, 1) ? 8'sh7F : 8'sh80;
				c.snr_avg  = $urandom_range(0, 1) ? 8'sh7F : 8'sh80;
			end
			default: ;
		endcase
		return c;
	endfunction

	task automatic push_run(input int len);
		rcbs_pkg::cand_t base;
		rcbs_pkg::cand_t c;
		base = fresh_cand();
		for (int i = 0; i < len; i++) begin
			c = ($urandom_range(0, 4) == 0) ? fresh_cand() : vary_cand(base);
			push_cand(c, $urandom_range(0, 4) != 0, i == len - 1);
			if ($urandom_range(0, 15) == 0) send_steady = !send_steady;
		end
	endtask

	initial begin
		int run_no;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// lone invalid candidate: nothing found
		push_fields(8'd0, 8'd0, 8'd0, 8'd0, 64'd0, 1'b0, 1'b1);
		// lone candidate at the top of every field
		push_fields(8'hFF, 8'hFF, 8'sh7F, 8'sh7F, '1, 1'b1, 1'b1);
		// preference decides
		push_fields(8'd10, 8'd9, 8'sd0, 8'sd0, 64'd1, 1'b1, 1'b0);
		push_fields(8'd200, 8'd9, 8'sd0, 8'sd0, 64'd1, 1'b1, 1'b0);
		push_fields(8'd5, 8'd0, 8'sh7F, 8'sh7F, 64'd0, 1'b1, 1'b1);
		// stratum decides, equal later candidate keeps the earlier one
		push_fields(8'd7, 8'd50, 8'sd1, 8'sd1, 64'd4, 1'b1, 1'b0);
		push_fields(8'd7, 8'd3, 8'sd1, 8'sd1, 64'd4, 1'b1, 1'b0);
		push_fields(8'd7, 8'd3, 8'sd1, 8'sd1, 64'd4, 1'b1, 1'b1);
		// score decides: the lowest, the highest and one just below it
		push_fields(8'd7, 8'd3, 8'sh80, 8'sh80, 64'd0, 1'b1, 1'b0);
		push_fields(8'd7, 8'd3, 8'sh7F, 8'sh7F, 64'd9, 1'b1, 1'b0);
		push_fields(8'd7, 8'd3, 8'sh7E, 8'sh7F, 64'd0, 1'b1, 1'b1);
		// equal score from another split, smaller identifier wins
		push_fields(8'd1, 8'd1, 8'sd10, 8'sd0, 64'd5, 1'b1, 1'b0);
		push_fields(8'd1, 8'd1, 8'sd5, 8'sd10, 64'd3, 1'b1, 1'b1);
		// identifier compared unsigned, zero is smallest
		push_fields(8'd2, 8'd2, 8'sd0, 8'sd0, 64'h8000_0000_0000_0000, 1'b1, 1'b0);
		push_fields(8'd2, 8'd2, 8'sd0, 8'sd0, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 1'b0);
		push_fields(8'd2, 8'd2, 8'sd0, 8'sd0, 64'd0, 1'b1, 1'b1);
		// a better candidate with a bad signature is skipped
		push_fields(8'hFF, 8'd0, 8'sh7F, 8'sh7F, 64'd0, 1'b0, 1'b0);
		push_fields(8'd0, 8'hFF, 8'sh80, 8'sh80, '1, 1'b1, 1'b1);
		// full tie keeps the first
		push_fields(8'd99, 8'd42, 8'sh90, 8'sd33, 64'hDEAD_BEEF_0123_4567, 1'b1, 1'b0);
		push_fields(8'd99, 8'd42, 8'sh90, 8'sd33, 64'hDEAD_BEEF_0123_4567, 1'b1, 1'b1);
		// two candidates, none valid
		push_fields(8'd3, 8'd3, 8'sd3, 8'sd3, 64'd3, 1'b0, 1'b0);
		push_fields(8'd4, 8'd4, 8'sd4, 8'sd4, 64'd4, 1'b0, 1'b1);

		// mostly short runs; a full-capacity run and two that spill past it
		run_no = 0;
		while (items_sent < ITEMS_TOTAL) begin
			case (run_no)
				2:       push_run(MAX_CANDIDATES);
				12:      push_run(MAX_CANDIDATES + 1);
				30:      push_run($urandom_range(MAX_CANDIDATES + 2, MAX_CANDIDATES + 44));
				default: push_run($urandom_range(1, 8));
			endcase
			run_no++;
		end
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (owed != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (fails == 0 && owed == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		int stall;
		int taken;
		taken = 0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (taken == 40) begin
				// long hold-off so the selector backs up into its input
				m_axis_tready <= 1'b0;
				repeat (300) @(posedge clk);
			end
			stall = recv_steady ? 0 : $urandom_range(0, 3);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			taken++;
			if ($urandom_range(0, 9) == 0) recv_steady = !recv_steady;
		end
	end

	initial begin
		#400_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

@@ root_candidate_best_select.f @@
src/rcbs_pkg.sv
src/root_candidate_best_select.sv
bench/best_select_check.sv
bench/tb_top.sv
